### sv/cbm_pkg.sv
package cbm_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_XLATE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // register decode: {address[14:13], address[0]}
   typedef enum logic [2:0] {
      REG_BANK_SELECT = 3'b000,
      REG_BANK_DATA   = 3'b001,
      REG_MIRRORING   = 3'b010,
      REG_RAM_PROTECT = 3'b011,
      REG_IRQ_LATCH   = 3'b100,
      REG_IRQ_RELOAD  = 3'b101,
      REG_IRQ_DISABLE = 3'b110,
      REG_IRQ_ENABLE  = 3'b111
   } reg_code_type;

   localparam logic       CSR_BANK_COUNT  = 1'b0;
   localparam logic       CSR_INIT_MIRROR = 1'b1;
   localparam int         CSR_DATA_WIDTH  = 6;

   localparam logic [2:0] PRG_REG_R6 = 3'd6;
   localparam logic [2:0] PRG_REG_R7 = 3'd7;

   localparam logic [5:0] BANK_COUNT_RESET = 6'd32;

   typedef struct packed {
      op_type      op;
      logic [14:0] cpu_address;
      logic [7:0]  write_data;
   } item_type;

   // program banking view used by translation
   typedef struct packed {
      logic       prg_mode;
      logic [5:0] r6;
      logic [5:0] r7;
   } prg_map_type;

   // status after the operation has taken effect
   typedef struct packed {
      logic irq_pending;
      logic mirroring;
   } status_type;

endpackage

### sv/cartridge_bank_mapper_irq_counter.sv
// Program-memory bank mapper with scanline IRQ counter. Each accepted word
// (register write, translate or tick) gives exactly one result word carrying
// the bank and offset of a translate (zero otherwise) and the IRQ and
// mirroring state after the operation. Each word passes an input register,
// then decode and bank selection into the result register. One
// word is taken every cycle while the result side keeps up; req_stall
// follows rsp_stall when both stages hold a word. csr writes must be made
// with no word in flight.
module cartridge_bank_mapper_irq_counter
   import cbm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_op,
   input  logic [14:0]               req_cpu_address,
   input  logic [7:0]                req_write_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [5:0]                rsp_prg_bank,
   output logic [12:0]               rsp_prg_offset,
   output logic                      rsp_irq_request,
   output logic                      rsp_mirroring_horizontal
);

   logic        bank_cnt_wr;
   logic        mirror_wr;
   logic [4:0]  bank_cnt_ff;
   logic        in_valid_ff;
   item_type    item_ff;
   logic        out_valid_ff;
   logic [5:0]  bank_ff,   bank_in;
   logic [12:0] offset_ff, offset_in;
   logic        irq_ff;
   logic        mirror_ff;
   logic        out_adv;
   logic        in_adv;
   logic [5:0]  xl_bank;
   logic [12:0] xl_offset;
   prg_map_type prg_map;
   status_type  status_next;

   assign bank_cnt_wr = csr_write_enable && csr_index == CSR_BANK_COUNT;
   assign mirror_wr   = csr_write_enable && csr_index == CSR_INIT_MIRROR;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_cnt_ff <= BANK_COUNT_RESET[4:0];
      end else if (bank_cnt_wr) begin
         bank_cnt_ff <= csr_write_data[4:0];
      end
   end

   // result register moves when empty or being taken
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_valid) begin
         item_ff.op          <= op_type'(req_op);
         item_ff.cpu_address <= req_cpu_address;
         item_ff.write_data  <= req_write_data;
      end
   end

   cbm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .commit       (in_valid_ff && out_adv),
      .item         (item_ff),
      .mirror_load  (mirror_wr),
      .mirror_value (csr_write_data[0]),
      .prg_map      (prg_map),
      .status_next  (status_next)
   );

   cbm_xlate u_xlate (
      .cpu_address (item_ff.cpu_address),
      .bank_count  (bank_cnt_ff),
      .prg_map     (prg_map),
      .prg_bank    (xl_bank),
      .prg_offset  (xl_offset)
   );

   assign bank_in   = (item_ff.op == OP_XLATE) ? xl_bank   : 6'd0;
   assign offset_in = (item_ff.op == OP_XLATE) ? xl_offset : 13'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && in_valid_ff) begin
         bank_ff   <= bank_in;
         offset_ff <= offset_in;
         irq_ff    <= status_next.irq_pending;
         mirror_ff <= status_next.mirroring;
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_prg_bank             = bank_ff;
   assign rsp_prg_offset           = offset_ff;
   assign rsp_irq_request          = irq_ff;
   assign rsp_mirroring_horizontal = mirror_ff;

endmodule

### sv/cbm_regs.sv
module cbm_regs
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        commit,
   input  item_type    item,
   input  logic        mirror_load,
   input  logic        mirror_value,
   output prg_map_type prg_map,
   output status_type  status_next
);

   logic [2:0]   bank_sel_ff,   bank_sel_in;
   logic         prg_mode_ff,   prg_mode_in;
   logic [5:0]   r6_ff,         r6_in;
   logic [5:0]   r7_ff,         r7_in;
   logic         mirror_ff,     mirror_in;
   logic [7:0]   latch_ff,      latch_in;
   logic [7:0]   counter_ff,    counter_in;
   logic         irq_en_ff,     irq_en_in;
   logic         irq_pend_ff,   irq_pend_in;
   reg_code_type reg_code;

   assign reg_code = reg_code_type'({item.cpu_address[14:13], item.cpu_address[0]});

   always_comb begin
      bank_sel_in = bank_sel_ff;
      prg_mode_in = prg_mode_ff;
      r6_in       = r6_ff;
      r7_in       = r7_ff;
      mirror_in   = mirror_ff;
      latch_in    = latch_ff;
      counter_in  = counter_ff;
      irq_en_in   = irq_en_ff;
      irq_pend_in = irq_pend_ff;
      case (item.op)
         OP_WRITE: begin
            case (reg_code)
               REG_BANK_SELECT: begin
                  bank_sel_in = item.write_data[2:0];
                  prg_mode_in = item.write_data[6];
               end
               REG_BANK_DATA: begin
                  // only r6 and r7 reach the program map
                  if (bank_sel_ff == PRG_REG_R6) begin
                     r6_in = item.write_data[5:0];
                  end
                  if (bank_sel_ff == PRG_REG_R7) begin
                     r7_in = item.write_data[5:0];
                  end
               end
               REG_MIRRORING:   mirror_in = item.write_data[0];
               REG_RAM_PROTECT: ;
               REG_IRQ_LATCH:   latch_in = item.write_data;
               REG_IRQ_RELOAD:  counter_in = 8'd0;
               REG_IRQ_DISABLE: begin
                  irq_en_in   = 1'b0;
                  irq_pend_in = 1'b0;
               end
               REG_IRQ_ENABLE:  irq_en_in = 1'b1;
               default: ;
            endcase
         end
         OP_TICK: begin
            counter_in = (counter_ff == 8'd0) ? latch_ff : counter_ff - 8'd1;
            if (irq_en_ff && counter_in == 8'd0) begin
               irq_pend_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_sel_ff <= '0;
         prg_mode_ff <= 1'b0;
         r6_ff       <= '0;
         r7_ff       <= '0;
         mirror_ff   <= 1'b0;
         latch_ff    <= '0;
         counter_ff  <= '0;
         irq_en_ff   <= 1'b0;
         irq_pend_ff <= 1'b0;
      end else if (mirror_load) begin
         mirror_ff <= mirror_value;
      end else if (commit) begin
         bank_sel_ff <= bank_sel_in;
         prg_mode_ff <= prg_mode_in;
         r6_ff       <= r6_in;
         r7_ff       <= r7_in;
         mirror_ff   <= mirror_in;
         latch_ff    <= latch_in;
         counter_ff  <= counter_in;
         irq_en_ff   <= irq_en_in;
         irq_pend_ff <= irq_pend_in;
      end
   end

   assign prg_map.prg_mode = prg_mode_ff;
   assign prg_map.r6       = r6_ff;
   assign prg_map.r7       = r7_ff;

   assign status_next.irq_pending = irq_pend_in;
   assign status_next.mirroring   = mirror_in;

endmodule

### sv/cbm_xlate.sv
module cbm_xlate
   import cbm_pkg::*;
(
   input  logic [14:0] cpu_address,
   input  logic [4:0]  bank_count,
   input  prg_map_type prg_map,
   output logic [5:0]  prg_bank,
   output logic [12:0] prg_offset
);

   logic [5:0] last_bank;
   logic [5:0] second_last_bank;

   // 2*count wraps at 64, so the top count bit drops out
   assign last_bank        = {bank_count, 1'b0} - 6'd1;
   assign second_last_bank = {bank_count, 1'b0} - 6'd2;

   always_comb begin
      case (cpu_address[14:13])
         2'd0:    prg_bank = prg_map.prg_mode ? second_last_bank : prg_map.r6;
         2'd1:    prg_bank = prg_map.r7;
         2'd2:    prg_bank = prg_map.prg_mode ? prg_map.r6 : second_last_bank;
         default: prg_bank = last_bank;
      endcase
   end

   assign prg_offset = cpu_address[12:0];

endmodule
